### rtl/two_wire_serial_frame_master_unit_defines.svh
// Assertion helpers for the two-wire serial frame master.
`ifndef TWO_WIRE_SERIAL_FRAME_MASTER_UNIT_DEFINES_SVH
`define TWO_WIRE_SERIAL_FRAME_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define TWSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define TWSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/twsf_pkg.sv
`timescale 1ns / 1ps
package twsf_pkg;

    // Transfer kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;
    localparam logic [1:0] KIND_UNDEF  = 2'd3;

    // Configuration register indexes (paddr[2])
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_DEV_ADDR    = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
    localparam logic [6:0] DEV_ADDR_RESET    = 7'h65;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int PADDR_W     = 3;

    // Frame segments
    typedef enum logic [12:0] {
        SEG_IDLE      = 13'b0_0000_0000_0001,
        SEG_ZERO_A    = 13'b0_0000_0000_0010,
        SEG_SYNC0_A   = 13'b0_0000_0000_0100,
        SEG_ZERO_B    = 13'b0_0000_0000_1000,
        SEG_SYNC1_A   = 13'b0_0000_0001_0000,
        SEG_DEV       = 13'b0_0000_0010_0000,
        SEG_SYNC1_B   = 13'b0_0000_0100_0000,
        SEG_REG       = 13'b0_0000_1000_0000,
        SEG_SYNC1_C   = 13'b0_0001_0000_0000,
        SEG_DATA      = 13'b0_0010_0000_0000,
        SEG_DATA_SYNC = 13'b0_0100_0000_0000,
        SEG_ZERO_END  = 13'b0_1000_0000_0000,
        SEG_SYNC_END  = 13'b1_0000_0000_0000
    } t_seg;

    // One result transaction
    typedef struct packed {
        logic       done_res;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       wr_taken;
        logic       busy_res;
        logic       data_drive;
        logic       data_out;
        logic       sck;
    } t_result;

    // Sync segments carry one bit, all others a byte.
    function automatic logic seg_is_sync(input t_seg seg);
        logic r;
        case (seg)
            SEG_SYNC0_A, SEG_SYNC1_A, SEG_SYNC1_B, SEG_SYNC1_C,
            SEG_DATA_SYNC, SEG_SYNC_END: r = 1'b1;
            default:                     r = 1'b0;
        endcase
        return r;
    endfunction

    // Plain in-order successor of the fixed header segments and of the closing zero byte.
    function automatic t_seg seg_next(input t_seg seg);
        t_seg r;
        case (seg)
            SEG_ZERO_A:   r = SEG_SYNC0_A;
            SEG_SYNC0_A:  r = SEG_ZERO_B;
            SEG_ZERO_B:   r = SEG_SYNC1_A;
            SEG_SYNC1_A:  r = SEG_DEV;
            SEG_DEV:      r = SEG_SYNC1_B;
            SEG_SYNC1_B:  r = SEG_REG;
            SEG_REG:      r = SEG_SYNC1_C;
            SEG_ZERO_END: r = SEG_SYNC_END;
            default:      r = SEG_IDLE;
        endcase
        return r;
    endfunction

endpackage

### rtl/two_wire_serial_frame_master_unit.sv
`timescale 1ns / 1ps
// Two-wire serial frame master. Each input transaction is one time tick of the bus timing;
// the block takes one per clock cycle whenever its output register is empty or being
// drained, and returns exactly one result transaction per tick in the following cycle. The
// whole per-tick update (phase counter, bit and segment sequencing, shift register) is a
// single registered pass, so throughput is one tick per cycle while results are taken.
// A start request while idle with nonzero length and a defined kind launches a frame:
// zero byte, sync 0, zero byte, sync 1, device address plus read bit, sync 1, register
// address, sync 1, data bytes each with a sync bit, then a zero byte and sync 0. Every
// bit is half_period_ticks ticks of SCK high followed by as many low. Write bytes are
// taken from wr_data on the tick that reports wr_taken; read bytes are sampled from
// data_in on the last tick of each high phase and reported with rd_valid.
// Registers: half_period_ticks at byte address 0, device_address at byte address 4.
module two_wire_serial_frame_master_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input tick stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // start_req[0], reg_addr[8:1], length[16:9], wr_data[24:17], data_in[25], zero fill
    input  logic [twsf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                           s_axis_tuser,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // sck[0], data_out[1], data_drive[2], busy_res[3], wr_taken[4], rd_valid[5],
    // rd_data[13:6], done_res[14], zero fill
    output logic [twsf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [twsf_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import twsf_pkg::*;
    `include "two_wire_serial_frame_master_unit_defines.svh"

    // Configuration registers
    logic [7:0] r_half;
    logic [6:0] r_dev;

    // Frame state
    t_seg       r_seg,         n_seg;
    logic [3:0] r_bit_index,   n_bit_index;
    logic [7:0] r_phase,       n_phase;
    logic       r_clock_high,  n_clock_high;
    logic [7:0] r_shift,       n_shift;
    logic [7:0] r_bytes_left,  n_bytes_left;
    logic [1:0] r_kind,        n_kind;
    logic [7:0] r_addr,        n_addr;

    // Output register
    logic    r_out_valid;
    t_result r_out, n_out;

    // Unpacked input fields
    logic       in_start;
    logic [1:0] in_kind;
    logic [7:0] in_reg_addr;
    logic [7:0] in_length;
    logic [7:0] in_wr_data;
    logic       in_data_in;
    logic       s_accept;
    logic       cfg_write;

    assign in_start    = s_axis_tdata[0];
    assign in_reg_addr = s_axis_tdata[8:1];
    assign in_length   = s_axis_tdata[16:9];
    assign in_wr_data  = s_axis_tdata[24:17];
    assign in_data_in  = s_axis_tdata[25];
    assign in_kind     = s_axis_tuser;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.done_res, r_out.rd_data, r_out.rd_valid,
                            r_out.wr_taken, r_out.busy_res, r_out.data_drive,
                            r_out.data_out, r_out.sck};

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_HALF_PERIOD: prdata = {24'd0, r_half};
            REG_DEV_ADDR:    prdata = {25'd0, r_dev};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_PERIOD_RESET;
            r_dev  <= DEV_ADDR_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_HALF_PERIOD: r_half <= pwdata[7:0];
                REG_DEV_ADDR:    r_dev  <= pwdata[6:0];
                default:         r_half <= r_half;
            endcase
        end
    end

    // Per-tick frame update and line levels
    always_comb begin
        logic       reading;
        logic [3:0] bi_inc;
        logic       seg_done;
        logic [2:0] bit_pos;
        logic       bit_val;

        n_seg        = r_seg;
        n_bit_index  = r_bit_index;
        n_phase      = r_phase;
        n_clock_high = r_clock_high;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_kind       = r_kind;
        n_addr       = r_addr;
        n_out        = '0;
        reading      = (r_seg == SEG_DATA) && (r_kind != KIND_WRITE);
        bi_inc       = r_bit_index + 4'd1;
        seg_done     = seg_is_sync(r_seg) ? (bi_inc >= 4'd1) : (bi_inc >= 4'd8);

        if (r_seg == SEG_IDLE) begin
            // Launch a frame on a valid request
            if (in_start && in_length != 8'd0 && in_kind != KIND_UNDEF) begin
                n_kind       = in_kind;
                n_addr       = in_reg_addr;
                n_bytes_left = (in_kind == KIND_SINGLE) ? 8'd1 : in_length;
                n_shift      = 8'd0;
                n_seg        = SEG_ZERO_A;
                n_bit_index  = 4'd0;
                n_clock_high = 1'b1;
                n_phase      = 8'd1;
            end
        end else if (r_phase < r_half) begin
            n_phase = r_phase + 8'd1;
        end else if (r_clock_high) begin
            // End of high phase: sample read data, drop the clock
            if (reading) begin
                n_shift = {r_shift[6:0], in_data_in};
                if (r_bit_index == 4'd7) begin
                    n_out.rd_valid = 1'b1;
                    n_out.rd_data  = n_shift;
                end
            end
            n_clock_high = 1'b0;
            n_phase      = 8'd1;
        end else begin
            // End of low phase: advance bit or segment
            if (!seg_done) begin
                n_bit_index = bi_inc;
            end else begin
                n_bit_index = 4'd0;
                case (r_seg)
                    SEG_SYNC1_C: begin
                        n_seg = SEG_DATA;
                        if (r_kind == KIND_WRITE) begin
                            n_shift        = in_wr_data;
                            n_out.wr_taken = 1'b1;
                        end else begin
                            n_shift = 8'd0;
                        end
                    end
                    SEG_DATA: n_seg = SEG_DATA_SYNC;
                    SEG_DATA_SYNC: begin
                        n_bytes_left = r_bytes_left - 8'd1;
                        if (n_bytes_left != 8'd0 && r_kind != KIND_SINGLE) begin
                            n_seg = SEG_DATA;
                            if (r_kind == KIND_WRITE) begin
                                n_shift        = in_wr_data;
                                n_out.wr_taken = 1'b1;
                            end else begin
                                n_shift = 8'd0;
                            end
                        end else begin
                            n_seg = SEG_ZERO_END;
                        end
                    end
                    SEG_SYNC_END: begin
                        n_seg          = SEG_IDLE;
                        n_out.done_res = 1'b1;
                    end
                    default: n_seg = seg_next(r_seg);
                endcase
            end
            if (n_seg == SEG_IDLE) begin
                n_clock_high = 1'b0;
                n_phase      = 8'd0;
            end else begin
                n_clock_high = 1'b1;
                n_phase      = 8'd1;
            end
        end

        // Bit on the line for the updated state
        bit_pos = n_bit_index[2:0];
        case (n_seg)
            SEG_SYNC1_A, SEG_SYNC1_B, SEG_SYNC1_C: bit_val = 1'b1;
            SEG_DEV: begin
                if (bit_pos != 3'd7) begin
                    bit_val = r_dev[3'd6 - bit_pos];
                end else begin
                    bit_val = (n_kind != KIND_WRITE);
                end
            end
            SEG_REG:  bit_val = n_addr[3'd7 - bit_pos];
            SEG_DATA: bit_val = n_shift[3'd7 - bit_pos];
            SEG_DATA_SYNC: begin
                bit_val = (n_kind == KIND_SINGLE) || (n_bytes_left > 8'd1);
            end
            default: bit_val = 1'b0;
        endcase

        if (n_seg == SEG_IDLE) begin
            n_out.sck        = 1'b0;
            n_out.data_out   = 1'b0;
            n_out.data_drive = 1'b1;
            n_out.busy_res   = 1'b0;
        end else begin
            n_out.sck        = n_clock_high;
            n_out.data_drive = !((n_seg == SEG_DATA) && (n_kind != KIND_WRITE));
            n_out.data_out   = n_out.data_drive && bit_val;
            n_out.busy_res   = 1'b1;
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg        <= SEG_IDLE;
            r_bit_index  <= 4'd0;
            r_phase      <= 8'd0;
            r_clock_high <= 1'b0;
            r_shift      <= 8'd0;
            r_bytes_left <= 8'd0;
            r_kind       <= KIND_WRITE;
            r_addr       <= 8'd0;
        end else if (s_accept) begin
            r_seg        <= n_seg;
            r_bit_index  <= n_bit_index;
            r_phase      <= n_phase;
            r_clock_high <= n_clock_high;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_kind       <= n_kind;
            r_addr       <= n_addr;
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= n_out;
        end
    end

    // Checks
    `TWSF_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, r_seg == SEG_IDLE,
        !r_clock_high && r_phase == 8'd0, "idle with running phase timer")
    `TWSF_ASSERT_NOW(a_bit_bound, i_clk, i_rst_n, 1'b1,
        r_bit_index < 4'd8, "bit index past a byte")
    `TWSF_ASSERT_NOW(a_read_released, i_clk, i_rst_n, r_out_valid && r_out.rd_valid,
        !r_out.data_drive && r_out.busy_res, "read byte reported while driving data")
    `TWSF_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, s_accept && n_out.done_res,
        r_seg == SEG_IDLE, "frame end without returning to idle")

endmodule
